// ----- src/csr_pkg.sv -----
// Shared types, constants and the angle mapping function for the coupled servo ramp.
`timescale 1ns / 1ps

package csr_pkg;

  localparam int ANGLE_W = 10;
  localparam int OFFSET_W = 9;
  localparam int START_W = 8;
  localparam int KIND_W = 3;
  localparam int TARGET_W = 8;
  localparam int DUR_IN_W = 16;
  localparam int IDX_W = 2;
  localparam int CFG_W = 9;
  localparam int MAG_W = ANGLE_W + 1;
  localparam int DURATION_BITS_DEF = 16;

  localparam logic [START_W-1:0] START_ANGLE_RST = START_W'(90);
  localparam logic signed [ANGLE_W+1:0] HALF_TURN = (ANGLE_W + 2)'(180);

  localparam logic [KIND_W-1:0] KIND_ENABLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RAMP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd4;

  localparam logic [IDX_W-1:0] REG_MIRROR = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [IDX_W-1:0] REG_START = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

  function automatic logic signed [ANGLE_W-1:0] map_second(
    input logic mirror,
    input logic signed [OFFSET_W-1:0] offset,
    input logic signed [ANGLE_W-1:0] pos
  );
    logic signed [ANGLE_W+1:0] p;
    logic signed [ANGLE_W+1:0] o;
    logic signed [ANGLE_W+1:0] r;
    p = {{2{pos[ANGLE_W-1]}}, pos};
    o = {{(ANGLE_W + 2 - OFFSET_W){offset[OFFSET_W-1]}}, offset};
    if (mirror) begin
      r = HALF_TURN - p - o;
    end else begin
      r = p + o;
    end
    return r[ANGLE_W-1:0];
  endfunction

endpackage

// ----- src/csr_muldiv.sv -----
// Shared shift-add multiplier and shift-subtract divider for one ramp point.
`timescale 1ns / 1ps

module csr_muldiv #(
  parameter int DURATION_BITS = csr_pkg::DURATION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [csr_pkg::MAG_W-1:0]  diff,
  input  logic [DURATION_BITS-1:0]          elapsed,
  input  logic [DURATION_BITS-1:0]          length,
  output csr_pkg::md_status_t               status,
  output logic signed [csr_pkg::MAG_W-1:0]  quot
);

  localparam int MW = csr_pkg::MAG_W;
  localparam int PW = DURATION_BITS + MW;
  localparam int CNT_W = $clog2(MW);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_phase_t;

  md_phase_t phase_r, phase_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] opb_r, opb_nxt;
  logic [MW-1:0] mag_r, mag_nxt;
  logic [DURATION_BITS-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt;
  logic done_r, done_nxt;
  logic sub;
  logic [PW:0] sum;
  logic last;

  assign sub = (phase_r == MD_DIV);
  assign sum = {1'b0, acc_r} + {1'b0, (sub ? ~opb_r : opb_r)} + (PW + 1)'(sub);
  assign last = (cnt_r == CNT_W'(MW - 1));

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    opb_nxt = opb_r;
    mag_nxt = mag_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    unique case (phase_r)
      MD_IDLE: begin
        if (start) begin
          phase_nxt = MD_MUL;
          acc_nxt = '0;
          opb_nxt = PW'(elapsed);
          mag_nxt = diff[MW-1] ? MW'(-diff) : MW'(diff);
          neg_nxt = diff[MW-1];
          len_nxt = length;
          cnt_nxt = '0;
        end
      end
      MD_MUL: begin
        if (mag_r[0]) begin
          acc_nxt = sum[PW-1:0];
        end
        opb_nxt = opb_r << 1;
        mag_nxt = mag_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          phase_nxt = MD_DIV;
          opb_nxt = {1'b0, len_r, {(MW - 1){1'b0}}};
          cnt_nxt = '0;
        end
      end
      MD_DIV: begin
        if (sum[PW]) begin
          acc_nxt = sum[PW-1:0];
        end
        mag_nxt = {mag_r[MW-2:0], sum[PW]};
        opb_nxt = opb_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          phase_nxt = MD_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: begin
        phase_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MD_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    opb_r <= opb_nxt;
    mag_r <= mag_nxt;
    len_r <= len_nxt;
    neg_r <= neg_nxt;
  end

  assign status.busy = (phase_r != MD_IDLE);
  assign status.done = done_r;
  assign quot = neg_r ? -$signed(mag_r) : $signed(mag_r);

  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(phase_r == MD_DIV))
    else $error("quotient flagged without a division step");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (phase_r == MD_IDLE))
    else $error("unit started while busy");

endmodule

// ----- src/coupled_servo_ramp.sv -----
// Top level of the coupled servo ramp: command sequencer, servo state and result register.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake          | Beat contents
//  cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//  in      | in        | in_valid/in_ready  | kind, target_angle, duration_ms
//  out     | out       | out_valid/out_ready| first/second angle, written, enabled, moving
//
//  Most beats produce their result in the cycle after acceptance.
//  A tick during a ramp runs two multiply-divide passes on the shared unit
//  (11 multiply steps and 11 divide steps each, handed off on the registered done flag)
//  and then loads the result register once the output is free.
//  Input is accepted when the sequencer is idle and the result register is free or draining.
//  Reset is synchronous and needs no clearing pass; a stalled result holds the sequencer.

module coupled_servo_ramp #(
  parameter int DURATION_BITS = csr_pkg::DURATION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [csr_pkg::IDX_W-1:0]            cfg_index,
  input  logic [csr_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [csr_pkg::KIND_W-1:0]           in_kind,
  input  logic [csr_pkg::TARGET_W-1:0]         in_target_angle,
  input  logic [csr_pkg::DUR_IN_W-1:0]         in_duration_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [csr_pkg::ANGLE_W-1:0]   out_first_angle,
  output logic signed [csr_pkg::ANGLE_W-1:0]   out_second_angle,
  output logic                                 out_angle_written,
  output logic                                 out_is_enabled,
  output logic                                 out_is_moving
);

  localparam int AW = csr_pkg::ANGLE_W;
  localparam int MW = csr_pkg::MAG_W;
  localparam int DB = DURATION_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FIRST  = 4'b0010,
    S_SECOND = 4'b0100,
    S_PUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic mirror_r, mirror_nxt;
  logic signed [csr_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [csr_pkg::START_W-1:0] start_r, start_nxt;
  logic en_r, en_nxt;
  logic ramp_r, ramp_nxt;
  logic [DB-1:0] elapsed_r, elapsed_nxt;
  logic [DB-1:0] length_r, length_nxt;
  logic signed [AW-1:0] first_cur_r, first_cur_nxt;
  logic signed [AW-1:0] second_cur_r, second_cur_nxt;
  logic signed [AW-1:0] first_from_r, first_from_nxt;
  logic signed [AW-1:0] first_to_r, first_to_nxt;
  logic signed [AW-1:0] second_from_r, second_from_nxt;
  logic signed [AW-1:0] second_to_r, second_to_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [AW-1:0] out_first_r, out_second_r;
  logic out_written_r, out_en_r, out_moving_r;
  logic out_load;
  logic written;

  logic [DB+csr_pkg::DUR_IN_W-1:0] dur_wide;
  logic [DB-1:0] dur;
  logic [DB-1:0] elapsed_inc;
  logic signed [AW-1:0] target;
  logic signed [MW-1:0] first_diff, second_diff;
  logic signed [MW-1:0] first_sum, second_sum;

  logic md_start;
  logic signed [MW-1:0] md_diff;
  csr_pkg::md_status_t md_status;
  logic signed [MW-1:0] md_quot;

  assign dur_wide = {{DB{1'b0}}, in_duration_ms};
  assign dur = dur_wide[DB-1:0];
  assign elapsed_inc = elapsed_r + DB'(1);
  assign target = {2'b00, in_target_angle};
  assign first_diff = {first_to_r[AW-1], first_to_r} - {first_from_r[AW-1], first_from_r};
  assign second_diff = {second_to_r[AW-1], second_to_r} - {second_from_r[AW-1], second_from_r};
  assign first_sum = {first_from_r[AW-1], first_from_r} + md_quot;
  assign second_sum = {second_from_r[AW-1], second_from_r} + md_quot;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    mirror_nxt = mirror_r;
    offset_nxt = offset_r;
    start_nxt = start_r;
    en_nxt = en_r;
    ramp_nxt = ramp_r;
    elapsed_nxt = elapsed_r;
    length_nxt = length_r;
    first_cur_nxt = first_cur_r;
    second_cur_nxt = second_cur_r;
    first_from_nxt = first_from_r;
    first_to_nxt = first_to_r;
    second_from_nxt = second_from_r;
    second_to_nxt = second_to_r;
    out_load = 1'b0;
    written = 1'b0;
    md_start = 1'b0;
    md_diff = first_diff;

    if (cfg_we) begin
      unique case (cfg_index)
        csr_pkg::REG_MIRROR: mirror_nxt = cfg_wdata[0];
        csr_pkg::REG_OFFSET: offset_nxt = $signed(cfg_wdata);
        csr_pkg::REG_START: start_nxt = cfg_wdata[csr_pkg::START_W-1:0];
        default: ;
      endcase
      if ((cfg_index == csr_pkg::REG_MIRROR || cfg_index == csr_pkg::REG_OFFSET ||
           cfg_index == csr_pkg::REG_START) && !en_r && !ramp_r) begin
        first_cur_nxt = {2'b00, start_nxt};
        second_cur_nxt = csr_pkg::map_second(mirror_nxt, offset_nxt, {2'b00, start_nxt});
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_load = 1'b1;
          unique case (in_kind)
            csr_pkg::KIND_ENABLE: begin
              if (!en_r) begin
                en_nxt = 1'b1;
                written = 1'b1;
              end
            end
            csr_pkg::KIND_DISABLE: begin
              en_nxt = 1'b0;
            end
            csr_pkg::KIND_MOVE: begin
              if (en_r) begin
                first_cur_nxt = target;
                second_cur_nxt = csr_pkg::map_second(mirror_r, offset_r, target);
                written = 1'b1;
              end
            end
            csr_pkg::KIND_RAMP: begin
              if (en_r) begin
                ramp_nxt = 1'b1;
                elapsed_nxt = '0;
                length_nxt = dur;
                first_from_nxt = first_cur_r;
                first_to_nxt = target;
                second_from_nxt = second_cur_r;
                second_to_nxt = csr_pkg::map_second(mirror_r, offset_r, target);
              end
            end
            csr_pkg::KIND_TICK: begin
              if (ramp_r) begin
                elapsed_nxt = elapsed_inc;
                if (elapsed_inc >= length_r) begin
                  ramp_nxt = 1'b0;
                  first_cur_nxt = first_to_r;
                  second_cur_nxt = second_to_r;
                  written = 1'b1;
                end else begin
                  out_load = 1'b0;
                  md_start = 1'b1;
                  md_diff = first_diff;
                  state_nxt = S_FIRST;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FIRST: begin
        if (md_status.done) begin
          first_cur_nxt = first_sum[AW-1:0];
          md_start = 1'b1;
          md_diff = second_diff;
          state_nxt = S_SECOND;
        end
      end
      S_SECOND: begin
        if (md_status.done) begin
          second_cur_nxt = second_sum[AW-1:0];
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          written = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mirror_r <= 1'b0;
      offset_r <= '0;
      start_r <= csr_pkg::START_ANGLE_RST;
      en_r <= 1'b0;
      ramp_r <= 1'b0;
      elapsed_r <= '0;
      length_r <= '0;
      first_cur_r <= {2'b00, csr_pkg::START_ANGLE_RST};
      second_cur_r <= csr_pkg::map_second(1'b0, '0, {2'b00, csr_pkg::START_ANGLE_RST});
      first_from_r <= '0;
      first_to_r <= '0;
      second_from_r <= '0;
      second_to_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mirror_r <= mirror_nxt;
      offset_r <= offset_nxt;
      start_r <= start_nxt;
      en_r <= en_nxt;
      ramp_r <= ramp_nxt;
      elapsed_r <= elapsed_nxt;
      length_r <= length_nxt;
      first_cur_r <= first_cur_nxt;
      second_cur_r <= second_cur_nxt;
      first_from_r <= first_from_nxt;
      first_to_r <= first_to_nxt;
      second_from_r <= second_from_nxt;
      second_to_r <= second_to_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_first_r <= first_cur_nxt;
      out_second_r <= second_cur_nxt;
      out_written_r <= written;
      out_en_r <= en_nxt;
      out_moving_r <= ramp_nxt;
    end
  end

  csr_muldiv #(
    .DURATION_BITS(DURATION_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .diff   (md_diff),
    .elapsed(elapsed_nxt),
    .length (length_r),
    .status (md_status),
    .quot   (md_quot)
  );

  assign out_valid = out_valid_r;
  assign out_first_angle = out_first_r;
  assign out_second_angle = out_second_r;
  assign out_angle_written = out_written_r;
  assign out_is_enabled = out_en_r;
  assign out_is_moving = out_moving_r;

  a_calc_needs_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ramp_r)
    else $error("ramp point computed without an active ramp");

  a_unit_busy_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRST || state_r == S_SECOND) |-> (md_status.busy || md_status.done))
    else $error("sequencer waits on an idle arithmetic unit");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_status.done |-> (state_r == S_FIRST || state_r == S_SECOND))
    else $error("arithmetic result arrived outside a calculation");

endmodule

// ----- bench/servo_pair_checker.sv -----
// Checker that predicts the coupled servo angles and compares every result beat.
`timescale 1ns / 1ps

module servo_pair_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [csr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [csr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [csr_pkg::KIND_W-1:0]         in_kind,
  input  logic [csr_pkg::TARGET_W-1:0]       in_target_angle,
  input  logic [csr_pkg::DUR_IN_W-1:0]       in_duration_ms,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [csr_pkg::ANGLE_W-1:0] out_first_angle,
  input  logic signed [csr_pkg::ANGLE_W-1:0] out_second_angle,
  input  logic                               out_angle_written,
  input  logic                               out_is_enabled,
  input  logic                               out_is_moving,
  output int                                 mismatch_count,
  output int                                 open_count,
  output int                                 results_seen,
  output int                                 ramp_steps
);
  import csr_pkg::*;

  localparam int HALF_SWEEP = 180;
  localparam int SHOWN_LIMIT = 10;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    angle_t first;
    angle_t second;
    logic   written;
    logic   enabled;
    logic   moving;
  } servo_report_t;

  logic                 mirror_on;
  logic signed [8:0]    offset_deg;
  logic [START_W-1:0]   start_deg;
  logic                 enabled;
  logic                 moving;
  logic [DUR_IN_W-1:0]  elapsed;
  logic [DUR_IN_W-1:0]  ramp_len;
  angle_t               cur_first;
  angle_t               cur_second;
  angle_t               from_first;
  angle_t               to_first;
  angle_t               from_second;
  angle_t               to_second;
  servo_report_t        expected_angles[$];
  int                   faults;
  int                   checked;
  int                   steps;

  function automatic angle_t second_for(input angle_t pos);
    int r;
    if (mirror_on) begin
      r = HALF_SWEEP - int'(pos) - int'(offset_deg);
    end else begin
      r = int'(pos) + int'(offset_deg);
    end
    return angle_t'(r);
  endfunction

  function automatic angle_t ramp_point(input angle_t from_a, input angle_t to_a);
    longint span;
    longint part;
    span = longint'(to_a) - longint'(from_a);
    part = (span * longint'(elapsed)) / longint'(ramp_len);
    return angle_t'(longint'(from_a) + part);
  endfunction

  function automatic void load_start();
    cur_first = angle_t'(int'(start_deg));
    cur_second = second_for(cur_first);
  endfunction

  function automatic servo_report_t advance_servos(input logic [KIND_W-1:0] kind,
                                                   input logic [TARGET_W-1:0] target,
                                                   input logic [DUR_IN_W-1:0] dur);
    servo_report_t rep;
    angle_t tgt;
    tgt = angle_t'(int'(target));
    rep.written = 1'b0;
    case (kind)
      KIND_ENABLE: begin
        if (!enabled) begin
          enabled = 1'b1;
          rep.written = 1'b1;
        end
      end
      KIND_DISABLE: begin
        enabled = 1'b0;
      end
      KIND_MOVE: begin
        if (enabled) begin
          cur_first = tgt;
          cur_second = second_for(tgt);
          rep.written = 1'b1;
        end
      end
      KIND_RAMP: begin
        if (enabled) begin
          moving = 1'b1;
          elapsed = '0;
          ramp_len = dur;
          from_first = cur_first;
          to_first = tgt;
          from_second = cur_second;
          to_second = second_for(tgt);
        end
      end
      KIND_TICK: begin
        if (moving) begin
          elapsed = elapsed + 1'b1;
          if (elapsed >= ramp_len) begin
            moving = 1'b0;
            cur_first = to_first;
            cur_second = to_second;
          end else begin
            cur_first = ramp_point(from_first, to_first);
            cur_second = ramp_point(from_second, to_second);
          end
          rep.written = 1'b1;
          steps++;
        end
      end
      default: begin
      end
    endcase
    rep.first = cur_first;
    rep.second = cur_second;
    rep.enabled = enabled;
    rep.moving = moving;
    return rep;
  endfunction

  always @(posedge clk) begin
    servo_report_t want;
    servo_report_t got;
    logic known_reg;
    if (!rst_n) begin
      mirror_on = 1'b0;
      offset_deg = '0;
      start_deg = START_ANGLE_RST;
      enabled = 1'b0;
      moving = 1'b0;
      elapsed = '0;
      ramp_len = '0;
      from_first = '0;
      to_first = '0;
      from_second = '0;
      to_second = '0;
      load_start();
      expected_angles.delete();
      faults = 0;
      checked = 0;
      steps = 0;
    end else begin
      if (cfg_we) begin
        known_reg = 1'b1;
        case (cfg_index)
          REG_MIRROR: mirror_on = cfg_wdata[0];
          REG_OFFSET: offset_deg = cfg_wdata[8:0];
          REG_START:  start_deg = cfg_wdata[START_W-1:0];
          default:    known_reg = 1'b0;
        endcase
        if (known_reg && !enabled && !moving) begin
          load_start();
        end
      end
      // The result of a beat leaves no earlier than the cycle after it enters, so pop first.
      if (out_valid && out_ready) begin
        got.first = out_first_angle;
        got.second = out_second_angle;
        got.written = out_angle_written;
        got.enabled = out_is_enabled;
        got.moving = out_is_moving;
        checked++;
        if (expected_angles.size() == 0) begin
          faults++;
          if (faults <= SHOWN_LIMIT) begin
            $display("%0t unexpected result beat: first=%0d second=%0d written=%0b enabled=%0b moving=%0b",
                     $time, got.first, got.second, got.written, got.enabled, got.moving);
          end
        end else begin
          want = expected_angles.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.written !== want.written || got.enabled !== want.enabled ||
              got.moving !== want.moving) begin
            faults++;
            if (faults <= SHOWN_LIMIT) begin
              $display("%0t mismatch: expected first=%0d second=%0d written=%0b enabled=%0b moving=%0b",
                       $time, want.first, want.second, want.written, want.enabled, want.moving);
              $display("%0t           actual first=%0d second=%0d written=%0b enabled=%0b moving=%0b",
                       $time, got.first, got.second, got.written, got.enabled, got.moving);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_angles.push_back(advance_servos(in_kind, in_target_angle, in_duration_ms));
      end
    end
    mismatch_count <= faults;
    open_count <= expected_angles.size();
    results_seen <= checked;
    ramp_steps <= steps;
  end

endmodule

// ----- bench/tb_coupled_servo_ramp.sv -----
// Testbench top for the coupled servo ramp: reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_coupled_servo_ramp;
  import csr_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 104;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_kind;
  logic [TARGET_W-1:0]       in_target_angle;
  logic [DUR_IN_W-1:0]       in_duration_ms;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [ANGLE_W-1:0] out_first_angle;
  logic signed [ANGLE_W-1:0] out_second_angle;
  logic                      out_angle_written;
  logic                      out_is_enabled;
  logic                      out_is_moving;

  int   mismatch_count;
  int   open_count;
  int   results_seen;
  int   ramp_steps;
  int   quiet_cycles = 0;
  int   pause_odds = 0;
  logic calm = 1'b0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  coupled_servo_ramp DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_target_angle   (in_target_angle),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_angle   (out_first_angle),
    .out_second_angle  (out_second_angle),
    .out_angle_written (out_angle_written),
    .out_is_enabled    (out_is_enabled),
    .out_is_moving     (out_is_moving)
  );

  servo_pair_checker watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_target_angle   (in_target_angle),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_angle   (out_first_angle),
    .out_second_angle  (out_second_angle),
    .out_angle_written (out_angle_written),
    .out_is_enabled    (out_is_enabled),
    .out_is_moving     (out_is_moving),
    .mismatch_count    (mismatch_count),
    .open_count        (open_count),
    .results_seen      (results_seen),
    .ramp_steps        (ramp_steps)
  );

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_command(input logic [KIND_W-1:0] kind,
                              input logic [TARGET_W-1:0] target,
                              input logic [DUR_IN_W-1:0] dur);
    in_kind = kind;
    in_target_angle = target;
    in_duration_ms = dur;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(1, 8) <= pause_odds) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic mirror, input logic [8:0] offset,
                               input logic [START_W-1:0] start);
    cfg_we = 1'b1;
    cfg_index = REG_MIRROR;
    cfg_wdata = CFG_W'(mirror);
    @(negedge clk);
    cfg_index = REG_OFFSET;
    cfg_wdata = CFG_W'(offset);
    @(negedge clk);
    cfg_index = REG_START;
    cfg_wdata = CFG_W'(start);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_command();
    int pick;
    logic [KIND_W-1:0] kind;
    logic [TARGET_W-1:0] target;
    logic [DUR_IN_W-1:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      kind = KIND_TICK;
    end else if (pick < 62) begin
      kind = KIND_RAMP;
    end else if (pick < 75) begin
      kind = KIND_MOVE;
    end else if (pick < 87) begin
      kind = KIND_ENABLE;
    end else if (pick < 94) begin
      kind = KIND_DISABLE;
    end else begin
      kind = KIND_W'($urandom_range(0, 7));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      target = '0;
    end else if (pick == 1) begin
      target = '1;
    end else if (pick == 2) begin
      target = TARGET_W'(180);
    end else begin
      target = TARGET_W'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      dur = DUR_IN_W'($urandom_range(0, 6));
    end else if (pick < 19) begin
      dur = DUR_IN_W'($urandom_range(7, 300));
    end else begin
      dur = DUR_IN_W'($urandom);
    end
    maybe_pause();
    send_command(kind, target, dur);
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_target_angle = '0;
    in_duration_ms = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pause_odds = 2;
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_MOVE, 8'd45, 16'd0);
    send_command(KIND_RAMP, 8'd10, 16'd5);
    send_command(KIND_ENABLE, 8'd0, 16'd0);
    send_command(KIND_ENABLE, 8'd0, 16'd0);
    send_command(KIND_MOVE, 8'd0, 16'd0);
    send_command(KIND_MOVE, 8'd255, 16'd0);
    send_command(KIND_RAMP, 8'd180, 16'd0);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_RAMP, 8'd0, 16'd3);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_MOVE, 8'd200, 16'd0);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_RAMP, 8'd255, 16'd4);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_DISABLE, 8'd0, 16'd0);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_TICK, 8'd0, 16'd0);
    send_command(KIND_TICK, 8'd0, 16'd0);
    for (int k = int'(KIND_TICK) + 1; k < (1 << KIND_W); k++) begin
      send_command(KIND_W'(k), 8'hA5, 16'h5A5A);
    end
    send_command(KIND_ENABLE, 8'd0, 16'd0);
    send_command(KIND_RAMP, 8'hFF, 16'hFFFF);
    send_command(KIND_TICK, 8'd0, 16'd0);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if ($urandom_range(0, 1) == 1) begin
        send_command(KIND_DISABLE, 8'd0, 16'd0);
        settle();
      end
      case (phase)
        0:       apply_setting(1'b1, 9'h0FF, 8'd0);
        1:       apply_setting(1'b0, 9'h100, 8'd255);
        2:       apply_setting(1'b1, 9'h100, 8'd255);
        3:       apply_setting(1'b0, 9'h0FF, 8'd0);
        default: apply_setting(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                               8'($urandom_range(0, 255)));
      endcase
      calm = (phase == PHASES - 1);
      pause_odds = calm ? 0 : $urandom_range(0, 3);
      repeat (PHASE_ITEMS) random_command();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result beats over %0d register settings, %0d of them ramp steps.",
             results_seen, PHASES + 1, ramp_steps);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
